/* design/efa_pkg.sv */
`default_nettype none
package efa_pkg;

    localparam int MAX_PIXELS_DEF = 262144;

    localparam int IDX_W = 24;
    localparam int COUNT_W = 32;
    localparam int PIX_W = 24;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic [1:0] ACT_EVENT = 2'd0;
    localparam logic [1:0] ACT_READ = 2'd1;
    localparam logic [1:0] ACT_READ_CLEAR = 2'd2;

    localparam logic [2:0] REG_ROI_X_START = 3'd0;
    localparam logic [2:0] REG_ROI_X_END = 3'd1;
    localparam logic [2:0] REG_ROI_Y_START = 3'd2;
    localparam logic [2:0] REG_ROI_Y_END = 3'd3;
    localparam logic [2:0] REG_ROW_STRIDE = 3'd4;
    localparam logic [2:0] REG_START_TIME = 3'd5;
    localparam logic [2:0] REG_ACC_MODE = 3'd6;
    localparam logic [2:0] REG_COLOR_PAIR = 3'd7;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_EVENT,
        OP_READ,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        logic [10:0] roi_x_start;
        logic [11:0] roi_x_end;
        logic [10:0] roi_y_start;
        logic [11:0] roi_y_end;
        logic [11:0] row_stride;
        logic [47:0] start_time;
        logic [1:0]  accumulate_mode;
        logic [15:0] color_pair;
    } t_cfg;

    typedef struct packed {
        t_op                op;
        logic [IDX_W-1:0]   addr;
        logic               polarity;
        logic               accepted;
        logic [COUNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic               accepted;
        logic [PIX_W-1:0]   pixel_value;
        logic [COUNT_W-1:0] batch_count;
    } t_result;

endpackage
`default_nettype wire

/* design/efa_front.sv */
`default_nettype none
module efa_front #(
    parameter int MAX_PIXELS = efa_pkg::MAX_PIXELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire efa_pkg::t_cfg i_cfg,
    input  wire logic          i_hold,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [1:0]    i_action,
    input  wire logic [10:0]   i_event_x,
    input  wire logic [10:0]   i_event_y,
    input  wire logic          i_event_polarity,
    input  wire logic [47:0]   i_event_time,
    input  wire logic [17:0]   i_pixel_index,
    input  wire logic          i_last_in_batch,
    output logic               o_push_valid,
    input  wire logic          i_push_ready,
    output efa_pkg::t_cmd      o_push_data
);
    import efa_pkg::*;

    localparam logic [IDX_W-1:0] MaxPix = IDX_W'(MAX_PIXELS);

    logic               r_s1_v;
    logic [1:0]         r_s1_action;
    logic               r_s1_keep;
    logic [10:0]        r_s1_dx;
    logic [10:0]        r_s1_dy;
    logic               r_s1_pol;
    logic [17:0]        r_s1_pidx;
    logic               r_s1_last;

    logic               r_s2_v;
    logic [1:0]         r_s2_action;
    logic               r_s2_keep;
    logic [22:0]        r_s2_prod;
    logic [10:0]        r_s2_dx;
    logic               r_s2_pol;
    logic [17:0]        r_s2_pidx;
    logic               r_s2_last;

    logic [COUNT_W-1:0] r_total;

    logic               en1;
    logic               en2;
    logic               in_fire;
    logic               push_fire;
    logic               n_keep;
    logic [22:0]        n_prod;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   pidx_ext;
    logic               ev_ok;
    logic               pidx_ok;
    logic [COUNT_W-1:0] total_inc;
    logic [COUNT_W-1:0] cnt;

    assign en2 = !r_s2_v || i_push_ready;
    assign en1 = !r_s1_v || en2;
    assign o_ready = en1 && !i_hold;
    assign in_fire = i_valid && o_ready;
    assign push_fire = r_s2_v && i_push_ready;

    assign n_keep = (i_action == ACT_EVENT) && (i_event_time >= i_cfg.start_time)
        && (i_event_x >= i_cfg.roi_x_start) && ({1'b0, i_event_x} < i_cfg.roi_x_end)
        && (i_event_y >= i_cfg.roi_y_start) && ({1'b0, i_event_y} < i_cfg.roi_y_end);

    assign n_prod = 23'(r_s1_dy) * 23'(i_cfg.row_stride);

    assign idx = IDX_W'(r_s2_prod) + IDX_W'(r_s2_dx);
    assign pidx_ext = IDX_W'(r_s2_pidx);
    assign ev_ok = r_s2_keep && (idx < MaxPix);
    assign pidx_ok = pidx_ext < MaxPix;
    assign total_inc = (r_total != '1) ? r_total + 1'b1 : r_total;
    assign cnt = ev_ok ? total_inc : r_total;

    always_comb begin
        o_push_data.op = OP_NONE;
        o_push_data.addr = pidx_ext;
        o_push_data.polarity = r_s2_pol;
        o_push_data.accepted = 1'b0;
        o_push_data.count = r_total;
        if (r_s2_action == ACT_EVENT) begin
            o_push_data.addr = idx;
            o_push_data.accepted = ev_ok;
            o_push_data.count = cnt;
            if (ev_ok) begin
                o_push_data.op = OP_EVENT;
            end
        end else if (pidx_ok && r_s2_action == ACT_READ) begin
            o_push_data.op = OP_READ;
        end else if (pidx_ok && r_s2_action == ACT_READ_CLEAR) begin
            o_push_data.op = OP_CLEAR;
        end
    end

    assign o_push_valid = r_s2_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_total <= '0;
        end else begin
            if (en1) begin
                r_s1_v <= in_fire;
            end
            if (en2) begin
                r_s2_v <= r_s1_v;
            end
            if (push_fire && r_s2_action == ACT_EVENT) begin
                r_total <= r_s2_last ? '0 : cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_s1_action <= i_action;
            r_s1_keep <= n_keep;
            r_s1_dx <= i_event_x - i_cfg.roi_x_start;
            r_s1_dy <= i_event_y - i_cfg.roi_y_start;
            r_s1_pol <= i_event_polarity;
            r_s1_pidx <= i_pixel_index;
            r_s1_last <= i_last_in_batch;
        end
        if (en2) begin
            r_s2_action <= r_s1_action;
            r_s2_keep <= r_s1_keep;
            r_s2_prod <= n_prod;
            r_s2_dx <= r_s1_dx;
            r_s2_pol <= r_s1_pol;
            r_s2_pidx <= r_s1_pidx;
            r_s2_last <= r_s1_last;
        end
    end

endmodule
`default_nettype wire

/* design/efa_queue.sv */
`default_nettype none
module efa_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push_valid,
    output logic               o_push_ready,
    input  wire efa_pkg::t_cmd i_push_data,
    output logic               o_pop_valid,
    input  wire logic          i_pop_ready,
    output efa_pkg::t_cmd      o_pop_data
);
    import efa_pkg::*;

    localparam logic [QPTR_W-1:0] LastSlot = QPTR_W'(QDEPTH - 1);
    localparam logic [QPTR_W:0] Full = (QPTR_W + 1)'(QDEPTH);

    t_cmd              r_slot [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    logic push;
    logic pop;

    assign o_push_ready = r_count != Full;
    assign o_pop_valid = r_count != '0;
    assign o_pop_data = r_slot[r_rd_ptr];
    assign push = i_push_valid && o_push_ready;
    assign pop = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LastSlot) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LastSlot) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_data;
        end
    end

endmodule
`default_nettype wire

/* design/efa_back.sv */
`default_nettype none
module efa_back #(
    parameter int MAX_PIXELS = efa_pkg::MAX_PIXELS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire efa_pkg::t_cfg i_cfg,
    output logic               o_clr_busy,
    input  wire logic          i_cmd_valid,
    output logic               o_cmd_ready,
    input  wire efa_pkg::t_cmd i_cmd,
    output logic               o_res_valid,
    input  wire logic          i_res_ready,
    output efa_pkg::t_result   o_res
);
    import efa_pkg::*;

    localparam int AW = $clog2(MAX_PIXELS);
    localparam logic [AW-1:0] LastAddr = AW'(MAX_PIXELS - 1);

    logic [PIX_W-1:0] r_mem [MAX_PIXELS];
    logic [PIX_W-1:0] r_rdata;
    t_cmd             r_b;
    logic             r_b_v;
    logic             r_fwd_v;
    logic [AW-1:0]    r_fwd_addr;
    logic [PIX_W-1:0] r_fwd_data;
    logic             r_clr_busy;
    logic [AW-1:0]    r_clr_addr;
    logic             r_out_v;
    t_result          r_out;

    logic             fire_b;
    logic             pop;
    logic [AW-1:0]    b_addr;
    logic [PIX_W-1:0] cur;
    logic [PIX_W-1:0] new_word;
    logic             op_write;
    logic             mem_we;
    logic [AW-1:0]    mem_wa;
    logic [PIX_W-1:0] mem_wd;
    logic [7:0]       pos;
    logic [7:0]       neg;
    logic [7:0]       color;
    logic             rgb;
    logic             hist;

    function automatic logic [7:0] sat_inc(input logic [7:0] b);
        sat_inc = (b != 8'hFF) ? b + 8'd1 : b;
    endfunction

    assign fire_b = r_b_v && (!r_out_v || i_res_ready);
    assign o_cmd_ready = !r_clr_busy && (!r_b_v || fire_b);
    assign pop = i_cmd_valid && o_cmd_ready;
    assign b_addr = r_b.addr[AW-1:0];

    assign cur = (r_fwd_v && r_fwd_addr == b_addr) ? r_fwd_data : r_rdata;
    assign pos = i_cfg.color_pair[15:8];
    assign neg = i_cfg.color_pair[7:0];
    assign rgb = i_cfg.accumulate_mode[0];
    assign hist = i_cfg.accumulate_mode[1];
    assign color = r_b.polarity ? pos : neg;

    always_comb begin
        new_word = cur;
        if (r_b.op == OP_CLEAR) begin
            new_word = '0;
        end else if (!hist && !rgb) begin
            new_word = {color, color, color};
        end else if (!hist) begin
            new_word = r_b.polarity ? {pos, cur[15:8], 8'h00} : {8'h00, cur[15:8], pos};
        end else if (rgb && r_b.polarity) begin
            new_word[23:16] = sat_inc(cur[23:16]);
        end else begin
            new_word[7:0] = sat_inc(cur[7:0]);
        end
    end

    assign op_write = (r_b.op == OP_EVENT) || (r_b.op == OP_CLEAR);
    assign mem_we = r_clr_busy || (fire_b && op_write);
    assign mem_wa = r_clr_busy ? r_clr_addr : b_addr;
    assign mem_wd = r_clr_busy ? '0 : new_word;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (pop) begin
            r_rdata <= r_mem[i_cmd.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
            r_out_v <= 1'b0;
            r_fwd_v <= 1'b0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LastAddr) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (pop) begin
                r_b_v <= 1'b1;
            end else if (fire_b) begin
                r_b_v <= 1'b0;
            end
            if (fire_b) begin
                r_out_v <= 1'b1;
            end else if (i_res_ready) begin
                r_out_v <= 1'b0;
            end
            if (fire_b && op_write) begin
                r_fwd_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b <= i_cmd;
        end
        if (fire_b && op_write) begin
            r_fwd_addr <= b_addr;
            r_fwd_data <= new_word;
        end
        if (fire_b) begin
            r_out.accepted <= r_b.accepted;
            r_out.batch_count <= r_b.count;
            r_out.pixel_value <= (r_b.op == OP_READ || r_b.op == OP_CLEAR) ? cur : '0;
        end
    end

    assign o_clr_busy = r_clr_busy;
    assign o_res_valid = r_out_v;
    assign o_res = r_out;

endmodule
`default_nettype wire

/* design/event_frame_accumulator.sv */
// Event frame accumulator.
// Slave stream: one item per event or pixel read. tuser carries the action
// (event, read, read and clear), tlast marks the last event of a batch and
// tdata carries coordinates, polarity, timestamp and the read address.
// Master stream: one result item per input item, in order. tuser is the
// accepted flag, tdata holds the pixel word read and the batch count.
// Registers are to be written over the APB port only while the block is
// idle; the user must keep to this, as the block does not enforce it.
// An item enters the filter stage, the index multiplier and the count
// update, waits in a four-entry queue, then reads and updates the frame
// memory through one registered read port and one write port. One item
// is taken per cycle while s_axis_tready is high; same-pixel updates are
// forwarded from the last write. After reset the frame memory, MAX_PIXELS
// words (262144 by default), is cleared one word per cycle; s_axis_tready
// stays low meanwhile. When m_axis_tready is held low, the output
// register, the pipeline and the queue fill, then s_axis_tready drops.
`default_nettype none
module event_frame_accumulator #(
    parameter int MAX_PIXELS = efa_pkg::MAX_PIXELS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x[10:0], y[21:11], polarity[22], time[70:23], pixel_index[88:71], zero fill
    input  wire logic [95:0] s_axis_tdata,
    // action[1:0]
    input  wire logic [1:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // pixel_value[23:0], batch_count[55:24]
    output logic [55:0]      m_axis_tdata,
    // accepted[0]
    output logic             m_axis_tuser,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready
);
    import efa_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic [2:0] reg_idx;
    logic    clr_busy;
    logic    push_valid;
    logic    push_ready;
    t_cmd    push_data;
    logic    pop_valid;
    logic    pop_ready;
    t_cmd    pop_data;
    t_result res;

    assign pready = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.roi_x_start <= 11'd0;
            r_cfg.roi_x_end <= 12'd2048;
            r_cfg.roi_y_start <= 11'd0;
            r_cfg.roi_y_end <= 12'd2048;
            r_cfg.row_stride <= 12'd512;
            r_cfg.start_time <= 48'd0;
            r_cfg.accumulate_mode <= 2'd0;
            r_cfg.color_pair <= 16'hFF00;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ROI_X_START: r_cfg.roi_x_start <= pwdata[10:0];
                REG_ROI_X_END:   r_cfg.roi_x_end <= pwdata[11:0];
                REG_ROI_Y_START: r_cfg.roi_y_start <= pwdata[10:0];
                REG_ROI_Y_END:   r_cfg.roi_y_end <= pwdata[11:0];
                REG_ROW_STRIDE:  r_cfg.row_stride <= pwdata[11:0];
                REG_START_TIME:  r_cfg.start_time <= pwdata[47:0];
                REG_ACC_MODE:    r_cfg.accumulate_mode <= pwdata[1:0];
                REG_COLOR_PAIR:  r_cfg.color_pair <= pwdata[15:0];
                default:         r_cfg.color_pair <= r_cfg.color_pair;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ROI_X_START: prdata = 64'(r_cfg.roi_x_start);
            REG_ROI_X_END:   prdata = 64'(r_cfg.roi_x_end);
            REG_ROI_Y_START: prdata = 64'(r_cfg.roi_y_start);
            REG_ROI_Y_END:   prdata = 64'(r_cfg.roi_y_end);
            REG_ROW_STRIDE:  prdata = 64'(r_cfg.row_stride);
            REG_START_TIME:  prdata = 64'(r_cfg.start_time);
            REG_ACC_MODE:    prdata = 64'(r_cfg.accumulate_mode);
            REG_COLOR_PAIR:  prdata = 64'(r_cfg.color_pair);
            default:         prdata = '0;
        endcase
    end

    efa_front #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_hold           (clr_busy),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_action         (s_axis_tuser),
        .i_event_x        (s_axis_tdata[10:0]),
        .i_event_y        (s_axis_tdata[21:11]),
        .i_event_polarity (s_axis_tdata[22]),
        .i_event_time     (s_axis_tdata[70:23]),
        .i_pixel_index    (s_axis_tdata[88:71]),
        .i_last_in_batch  (s_axis_tlast),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_push_data      (push_data)
    );

    efa_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_data  (push_data),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_data   (pop_data)
    );

    efa_back #(
        .MAX_PIXELS(MAX_PIXELS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .o_clr_busy  (clr_busy),
        .i_cmd_valid (pop_valid),
        .o_cmd_ready (pop_ready),
        .i_cmd       (pop_data),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_res       (res)
    );

    assign m_axis_tdata = {res.batch_count, res.pixel_value};
    assign m_axis_tuser = res.accepted;

    a_no_input_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !(s_axis_tvalid && s_axis_tready))
        else $error("item accepted during the frame clearing pass");

    a_no_result_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_busy |-> !m_axis_tvalid)
        else $error("result item shown during the frame clearing pass");

    a_accepted_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[55:24] != '0))
        else $error("accepted event with zero batch count");

    a_accepted_no_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[23:0] == '0))
        else $error("accepted event carries a pixel word");

endmodule
`default_nettype wire
